>>> rtl/mrc_pkg.sv
`default_nettype none

package mrc_pkg;

	localparam int WORD_COUNT  = 7;
	localparam int WORD_CHARS  = 11;
	localparam int CONNECT_LEN = 7;
	localparam int BAUD_W      = 24;
	localparam int TIMEOUT_W   = 8;
	localparam int ELAPSED_W   = 9;
	localparam int CFG_IDX_W   = 1;

	localparam logic [BAUD_W-1:0]    BAUD_MAX    = '1;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	// result codes
	localparam logic [1:0] RC_OK      = 2'd0;
	localparam logic [1:0] RC_CONNECT = 2'd1;
	localparam logic [1:0] RC_FAIL    = 2'd2;
	localparam logic [1:0] RC_NORESP  = 2'd3;

	// request types
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAUD    = 1'd1;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd2;
	localparam logic [BAUD_W-1:0]    BAUD_RST    = 24'd9600;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Result words, first character in the top byte of each entry; padding never compared.
	localparam logic [0:WORD_COUNT-1][0:WORD_CHARS-1][7:0] WORD_TEXT = {
		"OK         ",
		"NO CARRIER ",
		"ERROR      ",
		"NO DIALTONE",
		"BUSY       ",
		"NO ANSWER  ",
		"CONNECT    "
	};
	localparam logic [0:WORD_COUNT-1][3:0] WORD_LEN = {
		4'd2, 4'd10, 4'd5, 4'd11, 4'd4, 4'd9, 4'd7
	};
	localparam logic [0:WORD_COUNT-1][1:0] WORD_CODE = {
		RC_OK, RC_FAIL, RC_FAIL, RC_FAIL, RC_FAIL, RC_FAIL, RC_CONNECT
	};

	typedef enum logic [1:0] {
		SP_BLANK  = 2'd0,
		SP_DIGITS = 2'd1,
		SP_DONE   = 2'd2
	} speed_phase_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout_secs;
		logic [BAUD_W-1:0]    default_baud;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        result_code;
		logic [BAUD_W-1:0] baud;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/mrc_if.sv
`default_nettype none

interface mrc_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;
	modport source(output valid, output req_type, output rx_byte, input ready);
	modport sink(input valid, input req_type, input rx_byte, output ready);
endinterface

interface mrc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_code;
	logic [23:0] baud;
	modport source(output valid, output result_code, output baud, input ready);
	modport sink(input valid, input result_code, input baud, output ready);
endinterface

interface mrc_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [23:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/mrc_cfg_regs.sv
`default_nettype none

module mrc_cfg_regs (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mrc_cfg_if.sink    cfg,
	output mrc_pkg::cfg_t cfg_val
);
	import mrc_pkg::*;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic [BAUD_W-1:0]    baud_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			baud_q    <= BAUD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_TIMEOUT: timeout_q <= cfg.data[TIMEOUT_W-1:0];
				CFG_BAUD:    baud_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg_val.timeout_secs = timeout_q;
	assign cfg_val.default_baud = baud_q;

endmodule

`default_nettype wire

>>> rtl/mrc_line_tracker.sv
`default_nettype none

module mrc_line_tracker #(
	parameter int LINE_MAX = 127
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire mrc_pkg::item_t  item,
	input  wire mrc_pkg::cfg_t   cfg_val,
	output mrc_pkg::result_t     res
);
	import mrc_pkg::*;

	localparam int PW = $clog2(LINE_MAX + 1);

	logic [PW-1:0]         pos_q,   pos_d;
	logic [WORD_COUNT-1:0] match_q, match_d;
	speed_phase_t          phase_q, phase_d;
	logic                  neg_q,   neg_d;
	logic [BAUD_W-1:0]     accum_q, accum_d;
	logic [ELAPSED_W-1:0]  elapsed_q, elapsed_d;

	logic                 line_end;
	logic                 is_digit;
	logic [ELAPSED_W-1:0] elapsed_inc;
	logic [BAUD_W+3:0]    accum_next;
	logic                 hit;
	logic [1:0]           hit_code;
	logic [7:0]           c;

	assign c        = item.rx_byte;
	assign line_end = (c == CH_CR) || (c == CH_LF) || (pos_q >= PW'(LINE_MAX));
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
	// accum * 10 + digit, four spare bits for the saturation test
	assign accum_next = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} +
		(BAUD_W+4)'(c[3:0]);

	// first word still matching and long enough wins
	always_comb begin
		hit      = 1'b0;
		hit_code = RC_OK;
		for (int i = WORD_COUNT - 1; i >= 0; i--) begin
			if (match_q[i] && (pos_q >= PW'(WORD_LEN[i]))) begin
				hit      = 1'b1;
				hit_code = WORD_CODE[i];
			end
		end
	end

	always_comb begin
		pos_d     = pos_q;
		match_d   = match_q;
		phase_d   = phase_q;
		neg_d     = neg_q;
		accum_d   = accum_q;
		elapsed_d = elapsed_q;
		res       = '0;
		if (item.req_type == REQ_TICK) begin
			elapsed_d = elapsed_inc;
			if (elapsed_inc > {1'b0, cfg_val.timeout_secs}) begin
				res.valid       = 1'b1;
				res.result_code = RC_NORESP;
			end
		end else if (line_end) begin
			res.valid       = hit;
			res.result_code = hit_code;
			if (hit && (hit_code == RC_CONNECT)) begin
				res.baud = (neg_q || (accum_q == '0)) ? cfg_val.default_baud : accum_q;
			end
		end else begin
			for (int i = 0; i < WORD_COUNT; i++) begin
				if ((pos_q < PW'(WORD_LEN[i])) && (c != WORD_TEXT[i][pos_q[3:0]])) begin
					match_d[i] = 1'b0;
				end
			end
			if (pos_q >= PW'(CONNECT_LEN)) begin
				unique case (phase_q)
					SP_BLANK: begin
						if ((c == CH_SPACE) || (c == CH_TAB)) begin
							phase_d = SP_BLANK;
						end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
							neg_d   = (c == CH_MINUS);
							phase_d = SP_DIGITS;
						end else if (is_digit) begin
							accum_d = BAUD_W'(c[3:0]);
							phase_d = SP_DIGITS;
						end else begin
							phase_d = SP_DONE;
						end
					end
					SP_DIGITS: begin
						if (is_digit) begin
							accum_d = (accum_next > (BAUD_W+4)'(BAUD_MAX)) ?
								BAUD_MAX : accum_next[BAUD_W-1:0];
						end else begin
							phase_d = SP_DONE;
						end
					end
					default: ;
				endcase
			end
			pos_d = pos_q + 1'b1;
		end
		// any result or discarded line starts a fresh line
		if (res.valid || ((item.req_type == REQ_BYTE) && line_end)) begin
			pos_d     = '0;
			match_d   = '1;
			phase_d   = SP_BLANK;
			neg_d     = 1'b0;
			accum_d   = '0;
			elapsed_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			match_q   <= '1;
			phase_q   <= SP_BLANK;
			neg_q     <= 1'b0;
			accum_q   <= '0;
			elapsed_q <= '0;
		end else if (step) begin
			pos_q     <= pos_d;
			match_q   <= match_d;
			phase_q   <= phase_d;
			neg_q     <= neg_d;
			accum_q   <= accum_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/mrc_out_stage.sv
`default_nettype none

module mrc_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire mrc_pkg::result_t res,
	output logic                  free,
	mrc_rsp_if.source             rsp
);
	import mrc_pkg::*;

	logic              valid_q;
	logic [1:0]        code_q;
	logic [BAUD_W-1:0] baud_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			code_q <= res.result_code;
			baud_q <= res.baud;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.result_code = code_q;
	assign rsp.baud        = baud_q;

endmodule

`default_nettype wire

>>> rtl/modem_result_code_recognizer.sv
// Channel  Dir  Payload                          Transfer
// req      in   req_type[0], rx_byte[7:0]        valid & ready
// rsp      out  result_code[1:0], baud[23:0]     valid & ready
// cfg      in   index[0], data[23:0]             valid & ready (ready tied high)
//
// One item per cycle while rsp is not holding the output; an accepted item goes into the input
// register, then through the line tracker's single pass into the result register that drives rsp.
// Reset clears line state, timer and both pipeline valids; registers load defaults.
// req stalls only while a result sits in the output register and rsp is not ready.

`default_nettype none

module modem_result_code_recognizer #(
	parameter int LINE_MAX = 127
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mrc_req_if.sink   req,
	mrc_rsp_if.source rsp,
	mrc_cfg_if.sink   cfg
);
	import mrc_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_free;
	logic    advance;
	cfg_t    cfg_val;
	result_t res;

	assign advance   = valid_s1 && out_free;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type <= req.req_type;
			item_s1.rx_byte  <= req.rx_byte;
		end
	end

	mrc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_val (cfg_val)
	);

	mrc_line_tracker #(
		.LINE_MAX(LINE_MAX)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (item_s1),
		.cfg_val (cfg_val),
		.res     (res)
	);

	mrc_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.res    (res),
		.free   (out_free),
		.rsp    (rsp)
	);

`ifndef SYNTHESIS
	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (rsp.valid && !rsp.ready))
		else $error("req stalled without output backpressure");

	a_baud_zero_unless_connect: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.result_code != RC_CONNECT)) |-> (rsp.baud == '0))
		else $error("non-zero baud on a non-connect result");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> valid_s1)
		else $error("accepted item missing from input register");

	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(rsp.valid)) |-> $past(advance))
		else $error("result appeared without a processed item");
`endif

endmodule

`default_nettype wire
